/* design/stl_pkg.sv */
`default_nettype none

package stl_pkg;

  // Field widths of the token stream.
  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 24;
  localparam int KIND_BITS   = 6;
  localparam int ERR_BITS    = 3;

  // Token kinds.
  localparam logic [KIND_BITS-1:0] KIND_DOT     = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_SLASH   = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_EQ      = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_EQEQ    = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_LT      = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_LE      = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_GT      = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_GE      = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_COMMENT = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_STRING  = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_CHAR    = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_INT     = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_FLOAT   = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_KW0     = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_END     = 6'd52;
  localparam logic [KIND_BITS-1:0] KIND_NONE    = 6'd0;

  // Error codes.
  localparam logic [ERR_BITS-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_BITS-1:0] ERR_UNEXP    = 3'd1;
  localparam logic [ERR_BITS-1:0] ERR_UNT_STR  = 3'd2;
  localparam logic [ERR_BITS-1:0] ERR_UNT_CHR  = 3'd3;
  localparam logic [ERR_BITS-1:0] ERR_RESERVED = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_N      = 8'h6E;

  // Keyword table, right-justified text with its length.
  localparam int NKW        = 26;
  localparam int KW_MAXLEN  = 10;
  localparam logic [79:0] KW_TEXT [NKW] = '{
    80'("and"), 80'("else"), 80'("false"), 80'("function"), 80'("if"),
    80'("const"), 80'("none"), 80'("or"), 80'("print"), 80'h72656164_5f6c696e65,
    80'("return"), 80'("true"), 80'("repeat"), 80'("range"), 80'("not"),
    80'("break"), 80'("continue"), 80'("num32"), 80'("num"), 80'("float"),
    80'("bool"), 80'("char"), 80'("list"), 80'("dictionary"), 80'("string"),
    80'h726f785f726573756c74
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd3, 4'd4, 4'd5, 4'd8, 4'd2, 4'd5, 4'd4, 4'd2, 4'd5, 4'd9, 4'd6, 4'd4, 4'd6,
    4'd5, 4'd3, 4'd5, 4'd8, 4'd5, 4'd3, 4'd5, 4'd4, 4'd4, 4'd4, 4'd10, 4'd6, 4'd10
  };

  // Reserved identifier prefix, seven bytes, first byte in the top bits.
  localparam logic [55:0] PFX_TEXT = 56'h726f7876_32365f;
  localparam logic [2:0]  PFX_LEN  = 3'd7;

  // Identifier match state.
  typedef struct packed {
    logic [NKW-1:0] hits;
    logic [2:0]     phits;
    logic           plive;
    logic [3:0]     len;
  } id_t;

  localparam id_t ID_RESET = '{hits: '1, phits: 3'd0, plive: 1'b1, len: 4'd0};

  // One result item.
  typedef struct packed {
    logic [KIND_BITS-1:0]   token_kind;
    logic [ERR_BITS-1:0]    error_code;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line_number;
    logic                   last_of_run;
  } res_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_idch(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // Length between two offsets, never below zero.
  function automatic logic [OFFSET_BITS-1:0] span(logic [OFFSET_BITS-1:0] from,
                                                  logic [OFFSET_BITS-1:0] to);
    return (to >= from) ? (to - from) : '0;
  endfunction

  // Byte of a keyword at a position; only meaningful below its length.
  function automatic logic [7:0] kw_char(int k, logic [3:0] pos);
    logic [79:0] t;
    t = KW_TEXT[k] << (8'(8) * (8'(KW_MAXLEN) - 8'(KW_LEN[k]) + 8'(pos)));
    return t[79:72];
  endfunction

  // Advance the keyword and prefix match by one identifier byte.
  function automatic id_t id_feed(id_t s, logic [7:0] c);
    id_t r;
    logic [55:0] p;
    r = s;
    for (int k = 0; k < NKW; k++) begin
      if ((s.len >= KW_LEN[k]) || (kw_char(k, s.len) != c)) begin
        r.hits[k] = 1'b0;
      end
    end
    p = PFX_TEXT << (6'(8) * 6'(s.phits));
    if (s.plive && (s.phits < PFX_LEN)) begin
      if (p[55:48] == c) begin
        r.phits = s.phits + 3'd1;
      end else begin
        r.plive = 1'b0;
      end
    end
    if (s.len != 4'hF) begin
      r.len = s.len + 4'd1;
    end
    return r;
  endfunction

  // Kind of a finished identifier: a keyword whose full text matched, else ident.
  function automatic logic [KIND_BITS-1:0] id_kind(id_t s);
    logic [KIND_BITS-1:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < NKW; k++) begin
      if (s.hits[k] && (KW_LEN[k] == s.len)) begin
        kind = KIND_KW0 + KIND_BITS'(k);
      end
    end
    return kind;
  endfunction

  // One-character punctuation: valid bit, then the kind.
  function automatic logic [KIND_BITS:0] single_kind(logic [7:0] c);
    logic [KIND_BITS:0] r;
    unique case (c)
      8'h28:   r = {1'b1, 6'd0};
      8'h29:   r = {1'b1, 6'd1};
      8'h7B:   r = {1'b1, 6'd2};
      8'h7D:   r = {1'b1, 6'd3};
      8'h5B:   r = {1'b1, 6'd4};
      8'h5D:   r = {1'b1, 6'd5};
      8'h2C:   r = {1'b1, 6'd6};
      8'h2E:   r = {1'b1, 6'd7};
      8'h2D:   r = {1'b1, 6'd8};
      8'h2B:   r = {1'b1, 6'd9};
      8'h3B:   r = {1'b1, 6'd10};
      8'h2A:   r = {1'b1, 6'd11};
      8'h25:   r = {1'b1, 6'd12};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic res_t res_make(logic [KIND_BITS-1:0] kind, logic [ERR_BITS-1:0] err,
                                    logic [OFFSET_BITS-1:0] start,
                                    logic [OFFSET_BITS-1:0] len,
                                    logic [LINE_BITS-1:0] line);
    res_t r;
    r.token_kind   = kind;
    r.error_code   = err;
    r.start_offset = start;
    r.token_length = len;
    r.line_number  = line;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/stl_if.sv */
`default_nettype none

// Source byte channel.
interface stl_in_if;
  import stl_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_marker;

  modport source (output valid, output char_byte, output end_marker, input ready);
  modport sink (input valid, input char_byte, input end_marker, output ready);
endinterface

// Token result channel.
interface stl_out_if;
  import stl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   token_kind;
  logic [ERR_BITS-1:0]    error_code;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   line_number;
  logic                   last_of_run;

  modport source (output valid, output token_kind, output error_code, output start_offset,
                  output token_length, output line_number, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input error_code, input start_offset,
                input token_length, input line_number, input last_of_run,
                output ready);
endinterface

`default_nettype wire

/* design/source_text_lexer.sv */
// Streaming lexical scanner.
// in_i carries one source byte per transaction, or an end marker that flushes
// the pending token and, unless that token halts the scanner, produces an end
// token. out_o carries one token per transaction: kind, error code, start
// offset, length, line number, and a flag on the last token of a transaction.
// Each input transaction is scanned in the cycle it is accepted; its zero to
// three tokens are loaded into a three-entry result register and appear on
// out_o the next cycle, one per cycle. Throughput is one input transaction per
// cycle while each produces at most one token; a transaction with more tokens
// holds the input until all but its last are taken. The next input transaction
// is taken in the same cycle that the last buffered token is taken.
// When the receiver stalls, the buffered tokens hold and in_i is not ready.
// Reset clears the scanner to its idle state at offset zero, line one, with an
// empty result buffer. An identifier carrying the reserved prefix halts the
// scanner: later input transactions are taken and produce nothing until reset.
`default_nettype none

module source_text_lexer
  import stl_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  stl_in_if.sink    in_i,
  stl_out_if.source out_o
);

  typedef enum logic [15:0] {
    M_IDLE     = 16'h0001,
    M_SLASH    = 16'h0002,
    M_EQ       = 16'h0004,
    M_LT       = 16'h0008,
    M_GT       = 16'h0010,
    M_COMMENT  = 16'h0020,
    M_STR      = 16'h0040,
    M_CHR0     = 16'h0080,
    M_CHRESC   = 16'h0100,
    M_CHRCLOSE = 16'h0200,
    M_INT      = 16'h0400,
    M_DOT      = 16'h0800,
    M_FRAC     = 16'h1000,
    M_N        = 16'h2000,
    M_N3       = 16'h4000,
    M_ID       = 16'h8000
  } mode_e;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  id_t                    id_q, id_d;
  logic                   halt_q, halt_d;

  res_t                   res_q [3];
  res_t                   res_d [3];
  logic [1:0]             cnt_q;
  logic [1:0]             n_d;

  logic                   in_acc;
  logic                   out_acc;

  // Scan temporaries.
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] cur;
  logic [OFFSET_BITS-1:0] back1;
  logic [OFFSET_BITS-1:0] back2;
  logic                   do_idle;
  logic                   do_ident;
  id_t                    idv;
  logic [KIND_BITS:0]     sk;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Input is taken when the buffer is empty or its last token leaves now.
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.token_kind   = res_q[0].token_kind;
  assign out_o.error_code   = res_q[0].error_code;
  assign out_o.start_offset = res_q[0].start_offset;
  assign out_o.token_length = res_q[0].token_length;
  assign out_o.line_number  = res_q[0].line_number;
  assign out_o.last_of_run  = res_q[0].last_of_run;

  assign c     = in_i.char_byte;
  assign cur   = span(start_q, off_q);
  assign back1 = (off_q >= OFFSET_BITS'(1)) ? (off_q - OFFSET_BITS'(1)) : '0;
  assign back2 = (off_q >= OFFSET_BITS'(2)) ? (off_q - OFFSET_BITS'(2)) : '0;
  assign sk    = single_kind(c);

  // Scan one byte or the end marker against the current state.
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    off_d    = off_q;
    line_d   = line_q;
    id_d     = id_q;
    halt_d   = halt_q;
    n_d      = 2'd0;
    do_idle  = 1'b0;
    do_ident = 1'b0;
    idv      = id_q;
    for (int i = 0; i < 3; i++) begin
      res_d[i] = '0;
    end

    if (halt_q) begin
      // Halted: nothing changes.
    end else if (in_i.end_marker) begin
      unique case (mode_q)
        M_IDLE: begin
        end
        M_SLASH: begin
          res_d[n_d] = res_make(KIND_SLASH, ERR_NONE, start_q, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end
        M_EQ: begin
          res_d[n_d] = res_make(KIND_EQ, ERR_NONE, start_q, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end
        M_LT: begin
          res_d[n_d] = res_make(KIND_LT, ERR_NONE, start_q, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end
        M_GT: begin
          res_d[n_d] = res_make(KIND_GT, ERR_NONE, start_q, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end
        M_COMMENT: begin
          res_d[n_d] = res_make(KIND_COMMENT, ERR_NONE, start_q, cur, line_q);
          n_d = n_d + 2'd1;
        end
        M_STR: begin
          res_d[n_d] = res_make(KIND_NONE, ERR_UNT_STR, start_q, cur, line_q);
          n_d = n_d + 2'd1;
        end
        M_CHR0, M_CHRESC, M_CHRCLOSE: begin
          res_d[n_d] = res_make(KIND_NONE, ERR_UNT_CHR, start_q, cur, line_q);
          n_d = n_d + 2'd1;
        end
        M_INT: begin
          res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, cur, line_q);
          n_d = n_d + 2'd1;
        end
        M_DOT: begin
          res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, span(start_q, back1), line_q);
          n_d = n_d + 2'd1;
          res_d[n_d] = res_make(KIND_DOT, ERR_NONE, back1, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end
        M_FRAC: begin
          res_d[n_d] = res_make(KIND_FLOAT, ERR_NONE, start_q, cur, line_q);
          n_d = n_d + 2'd1;
        end
        M_N: begin
          res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, span(start_q, back1), line_q);
          n_d = n_d + 2'd1;
          idv = id_feed(ID_RESET, CH_N);
          res_d[n_d] = res_make(id_kind(idv), ERR_NONE, back1, span(back1, off_q), line_q);
          n_d = n_d + 2'd1;
        end
        M_N3: begin
          res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, span(start_q, back2), line_q);
          n_d = n_d + 2'd1;
          idv = id_feed(id_feed(ID_RESET, CH_N), CH_3);
          res_d[n_d] = res_make(id_kind(idv), ERR_NONE, back2, span(back2, off_q), line_q);
          n_d = n_d + 2'd1;
        end
        M_ID: begin
          if (id_q.phits == PFX_LEN) begin
            res_d[n_d] = res_make(KIND_NONE, ERR_RESERVED, start_q, cur, line_q);
            n_d = n_d + 2'd1;
            halt_d = 1'b1;
          end else begin
            res_d[n_d] = res_make(id_kind(id_q), ERR_NONE, start_q, cur, line_q);
            n_d = n_d + 2'd1;
          end
        end
        default: begin
        end
      endcase
      // End token, then back to the reset state, unless the scanner halted.
      if (!halt_d) begin
        res_d[n_d] = res_make(KIND_END, ERR_NONE, off_q, '0, line_q);
        n_d = n_d + 2'd1;
        mode_d  = M_IDLE;
        start_d = '0;
        off_d   = '0;
        line_d  = LINE_BITS'(1);
        id_d    = ID_RESET;
      end
    end else begin
      unique case (mode_q)
        M_IDLE: do_idle = 1'b1;
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_d = M_COMMENT;
          end else begin
            res_d[n_d] = res_make(KIND_SLASH, ERR_NONE, start_q, OFFSET_BITS'(1), line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_EQ, M_LT, M_GT: begin
          logic [KIND_BITS-1:0] one;
          one = (mode_q == M_EQ) ? KIND_EQ : (mode_q == M_LT) ? KIND_LT : KIND_GT;
          if (c == CH_EQ) begin
            res_d[n_d] = res_make(one + KIND_BITS'(1), ERR_NONE, start_q, OFFSET_BITS'(2),
                                  line_q);
            n_d = n_d + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res_d[n_d] = res_make(one, ERR_NONE, start_q, OFFSET_BITS'(1), line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) begin
            res_d[n_d] = res_make(KIND_COMMENT, ERR_NONE, start_q, cur, line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_DQUOTE) begin
            res_d[n_d] = res_make(KIND_STRING, ERR_NONE, start_q, cur + OFFSET_BITS'(1),
                                  line_q);
            n_d = n_d + 2'd1;
            mode_d = M_IDLE;
          end else if ((c == CH_LF) && (line_q != LINE_MAX)) begin
            line_d = line_q + LINE_BITS'(1);
          end
        end
        M_CHR0: mode_d = (c == CH_BSLASH) ? M_CHRESC : M_CHRCLOSE;
        M_CHRESC: mode_d = M_CHRCLOSE;
        M_CHRCLOSE: begin
          if (c == CH_SQUOTE) begin
            res_d[n_d] = res_make(KIND_CHAR, ERR_NONE, start_q, cur + OFFSET_BITS'(1),
                                  line_q);
            n_d = n_d + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res_d[n_d] = res_make(KIND_NONE, ERR_UNT_CHR, start_q, cur, line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_INT: begin
          priority if (is_digit(c)) begin
            mode_d = M_INT;
          end else if (c == CH_DOT) begin
            mode_d = M_DOT;
          end else if (c == CH_N) begin
            mode_d = M_N;
          end else begin
            res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, cur, line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            mode_d = M_FRAC;
          end else begin
            res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, span(start_q, back1), line_q);
            n_d = n_d + 2'd1;
            res_d[n_d] = res_make(KIND_DOT, ERR_NONE, back1, OFFSET_BITS'(1), line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (!is_digit(c)) begin
            res_d[n_d] = res_make(KIND_FLOAT, ERR_NONE, start_q, cur, line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_N: begin
          if (c == CH_3) begin
            mode_d = M_N3;
          end else begin
            res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, span(start_q, back1), line_q);
            n_d = n_d + 2'd1;
            start_d  = back1;
            idv      = id_feed(ID_RESET, CH_N);
            do_ident = 1'b1;
          end
        end
        M_N3: begin
          if (c == CH_2) begin
            res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, cur + OFFSET_BITS'(1), line_q);
            n_d = n_d + 2'd1;
            mode_d = M_IDLE;
          end else begin
            res_d[n_d] = res_make(KIND_INT, ERR_NONE, start_q, span(start_q, back2), line_q);
            n_d = n_d + 2'd1;
            start_d  = back2;
            idv      = id_feed(id_feed(ID_RESET, CH_N), CH_3);
            do_ident = 1'b1;
          end
        end
        M_ID: do_ident = 1'b1;
        default: begin
        end
      endcase

      // Identifier continues or closes.
      if (do_ident) begin
        if (is_idch(c)) begin
          id_d   = id_feed(idv, c);
          mode_d = M_ID;
        end else begin
          mode_d = M_IDLE;
          if (idv.phits == PFX_LEN) begin
            res_d[n_d] = res_make(KIND_NONE, ERR_RESERVED, start_d, span(start_d, off_q),
                                  line_q);
            n_d = n_d + 2'd1;
            halt_d = 1'b1;
          end else begin
            res_d[n_d] = res_make(id_kind(idv), ERR_NONE, start_d, span(start_d, off_q),
                                  line_q);
            n_d = n_d + 2'd1;
            do_idle = 1'b1;
          end
        end
      end

      // The byte starts new text.
      if (do_idle) begin
        start_d = off_q;
        mode_d  = M_IDLE;
        priority if (sk[KIND_BITS]) begin
          res_d[n_d] = res_make(sk[KIND_BITS-1:0], ERR_NONE, off_q, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end else if (c == CH_EQ) begin
          mode_d = M_EQ;
        end else if (c == CH_LT) begin
          mode_d = M_LT;
        end else if (c == CH_GT) begin
          mode_d = M_GT;
        end else if (c == CH_SLASH) begin
          mode_d = M_SLASH;
        end else if ((c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB)) begin
          mode_d = M_IDLE;
        end else if (c == CH_LF) begin
          if (line_q != LINE_MAX) begin
            line_d = line_q + LINE_BITS'(1);
          end
        end else if (c == CH_DQUOTE) begin
          mode_d = M_STR;
        end else if (c == CH_SQUOTE) begin
          mode_d = M_CHR0;
        end else if (is_digit(c)) begin
          mode_d = M_INT;
        end else if (is_alpha(c)) begin
          id_d   = id_feed(ID_RESET, c);
          mode_d = M_ID;
        end else begin
          res_d[n_d] = res_make(KIND_NONE, ERR_UNEXP, off_q, OFFSET_BITS'(1), line_q);
          n_d = n_d + 2'd1;
        end
      end

      if (off_q != OFF_MAX) begin
        off_d = off_q + OFFSET_BITS'(1);
      end
    end

    // Flag the last token of this transaction.
    for (int i = 0; i < 3; i++) begin
      if ((n_d != 2'd0) && (2'(i) == (n_d - 2'd1))) begin
        res_d[i].last_of_run = 1'b1;
      end
    end
  end

  // Scanner state, updated on every accepted input transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      off_q   <= '0;
      line_q  <= LINE_BITS'(1);
      id_q    <= ID_RESET;
      halt_q  <= 1'b0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      off_q   <= off_d;
      line_q  <= line_d;
      id_q    <= id_d;
      halt_q  <= halt_d;
    end
  end

  // Result buffer occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_acc) begin
      cnt_q <= n_d;
    end else if (out_acc) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result buffer contents; entry zero drives the output.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end else if (out_acc) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

`ifndef NO_ASSERTIONS
  // Once halted, the scanner stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt state cleared without reset");

  // The presented token carries the last flag exactly when it is the last buffered.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_of_run == (cnt_q == 2'd1)))
    else $error("last_of_run does not match buffer occupancy");

  // The line counter never drops to zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");
`endif

endmodule

`default_nettype wire
